[hw/rtl/dpcm_pkg.sv]
// Package for the raw-sensor DPCM pixel decoder: pixel and mode types,
// register indexes and the per-format code decoding functions.
// No dependencies.
`default_nettype none

package dpcm_pkg;

  localparam int unsigned PIXEL_BITS = 12;
  localparam int unsigned LINE_W_BITS = 14;
  localparam int unsigned CFG_IDX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS = 16;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [2:0] mode_t;
  typedef logic [LINE_W_BITS-1:0] line_w_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  // Codec mode codes; the unused codes act as bypass
  localparam mode_t MODE_BYPASS  = 3'd0;
  localparam mode_t MODE_DPCM_10 = 3'd1;
  localparam mode_t MODE_DPCM_8  = 3'd2;
  localparam mode_t MODE_DPCM_7  = 3'd3;
  localparam mode_t MODE_DPCM_6  = 3'd4;

  // Configuration register indexes
  localparam cfg_idx_t REG_CODEC_MODE = 8'd0;
  localparam cfg_idx_t REG_LINE_WIDTH = 8'd1;

  localparam pix_t PIX_MAX = 12'd4095;

  localparam mode_t   MODE_RESET = MODE_DPCM_6;
  localparam line_w_t LINE_W_RESET = 14'd1920;

  // Add or subtract a magnitude from the prediction, clamped to the pixel range
  function automatic pix_t diff_apply(input pix_t pred, input logic neg, input pix_t mag);
    logic [PIXEL_BITS:0] sum;
    pix_t res;
    sum = {1'b0, pred} + {1'b0, mag};
    if (neg) begin
      res = (mag >= pred) ? '0 : pred - mag;
    end else begin
      res = (sum > {1'b0, PIX_MAX}) ? PIX_MAX : sum[PIXEL_BITS-1:0];
    end
    return res;
  endfunction

  // Reconstruct a PCM-coded value inside a DPCM line
  function automatic pix_t pcm_apply(input pix_t pred, input pix_t half, input pix_t v);
    return (v > pred) ? v + half : v + half + 12'd1;
  endfunction

  // 12-10-12
  function automatic pix_t dec_10(input logic raw, input logic [9:0] c, input pix_t p);
    pix_t res;
    if (raw) begin
      res = (12'(c) << 2) + 12'd2;
    end else if (c[9:8] == 2'b00) begin
      res = diff_apply(p, c[7], 12'(c[6:0]));
    end else if (c[9:7] == 3'b010) begin
      res = diff_apply(p, c[6], (12'(c[5:0]) << 1) + 12'd128);
    end else if (c[9:7] == 3'b011) begin
      res = diff_apply(p, c[6], (12'(c[5:0]) << 2) + 12'd257);
    end else begin
      res = pcm_apply(p, 12'd3, 12'(c[8:0]) << 3);
    end
    return res;
  endfunction

  // 12-8-12
  function automatic pix_t dec_8(input logic raw, input logic [7:0] c, input pix_t p);
    pix_t res;
    if (raw) begin
      res = (12'(c) << 4) + 12'd8;
    end else if (c[7:4] == 4'b0000) begin
      res = diff_apply(p, c[3], 12'(c[2:0]));
    end else if (c[7:5] == 3'b011) begin
      res = diff_apply(p, c[4], (12'(c[3:0]) << 1) + 12'd8);
    end else if (c[7:5] == 3'b010) begin
      res = diff_apply(p, c[4], (12'(c[3:0]) << 2) + 12'd41);
    end else if (c[7:5] == 3'b001) begin
      res = diff_apply(p, c[4], (12'(c[3:0]) << 3) + 12'd107);
    end else if (c[7:4] == 4'b0001) begin
      res = diff_apply(p, c[3], (12'(c[2:0]) << 4) + 12'd239);
    end else begin
      res = pcm_apply(p, 12'd15, 12'(c[6:0]) << 5);
    end
    return res;
  endfunction

  // 12-7-12
  function automatic pix_t dec_7(input logic raw, input logic [6:0] c, input pix_t p);
    pix_t res;
    if (raw) begin
      res = (12'(c) << 5) + 12'd16;
    end else if (c[6:3] == 4'b0000) begin
      res = diff_apply(p, c[2], 12'(c[1:0]));
    end else if (c[6:3] == 4'b0001) begin
      res = diff_apply(p, c[2], (12'(c[1:0]) << 1) + 12'd4);
    end else if (c[6:3] == 4'b0010) begin
      res = diff_apply(p, c[2], (12'(c[1:0]) << 2) + 12'd13);
    end else if (c[6:4] == 3'b010) begin
      res = diff_apply(p, c[3], (12'(c[2:0]) << 3) + 12'd31);
    end else if (c[6:4] == 3'b011) begin
      res = diff_apply(p, c[3], (12'(c[2:0]) << 4) + 12'd99);
    end else if (c[6:3] == 4'b0011) begin
      res = diff_apply(p, c[2], (12'(c[1:0]) << 5) + 12'd235);
    end else begin
      res = pcm_apply(p, 12'd31, 12'(c[5:0]) << 6);
    end
    return res;
  endfunction

  // 12-6-12
  function automatic pix_t dec_6(input logic raw, input logic [5:0] c, input pix_t p);
    pix_t res;
    if (raw) begin
      res = (12'(c) << 6) + 12'd32;
    end else if (c[5:2] == 4'b0000) begin
      res = diff_apply(p, c[1], 12'(c[0]));
    end else if (c[5:2] == 4'b0001) begin
      res = diff_apply(p, c[1], (12'(c[0]) << 2) + 12'd3);
    end else if (c[5:3] == 3'b010) begin
      res = diff_apply(p, c[2], (12'(c[1:0]) << 3) + 12'd13);
    end else if (c[5:2] == 4'b0010) begin
      res = diff_apply(p, c[1], (12'(c[0]) << 4) + 12'd49);
    end else if (c[5:3] == 3'b011) begin
      res = diff_apply(p, c[2], (12'(c[1:0]) << 5) + 12'd89);
    end else if (c[5:2] == 4'b0011) begin
      res = diff_apply(p, c[1], (12'(c[0]) << 6) + 12'd233);
    end else begin
      res = pcm_apply(p, 12'd63, 12'(c[4:0]) << 7);
    end
    return res;
  endfunction

  // True when both pairs move in the same direction (or stay flat)
  function automatic logic ordered(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
    return ((a <= b) && (c <= d)) || ((a >= b) && (c >= d));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dpcm_raw_pixel_decoder.sv]
// Raw-sensor DPCM pixel decoder top level: input register, decode logic,
// column counter, pixel history and output register.
// Depends on dpcm_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_code_word) takes one compressed code
//   per pixel. Output channel (out_valid/out_ready) returns the decoded 12-bit
//   pixel and an end-of-line flag, one result item per input item, in order.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_wdata) writes index 0
//   codec_mode and index 1 line_width; cfg_ready is always high. Write config
//   only while no item is in flight.
//   Path: an accepted item loads the input register; its decoded result
//   then loads the output register once that register is free.
//   Throughput: one item per cycle while out_ready is high; the decode of an
//   item and the history/column update are done between the two registers.
//   Reset: codec_mode 4 (12-6-12), line_width 1920, column counter and
//   pixel history cleared, both pipeline registers empty.
//   Stall: when out_ready is low the output register holds its item, the
//   input register still fills once, then in_ready drops until the result
//   is taken.
`default_nettype none

module dpcm_raw_pixel_decoder #(
  parameter int unsigned MAX_LINE_WIDTH = 8192
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  dpcm_pkg::pix_t        in_code_word,
  output logic                  out_valid,
  input  wire                   out_ready,
  output dpcm_pkg::pix_t        out_pixel_value,
  output logic                  out_end_of_line,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  dpcm_pkg::cfg_idx_t    cfg_index,
  input  dpcm_pkg::cfg_data_t   cfg_wdata
);
  import dpcm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned EW = ((CW + 1) > LINE_W_BITS) ? (CW + 1) : LINE_W_BITS;

  // Configuration registers
  mode_t   mode_r;
  line_w_t line_w_r;

  // Pipeline registers
  logic    s1_valid_r;
  pix_t    s1_code_r;
  logic    out_valid_r;
  pix_t    out_pix_r;
  logic    out_eol_r;

  // Decoder state
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  pix_t hist0_r, hist1_r, hist2_r, hist3_r;

  logic    advance;
  logic [EW-1:0] lw_ext;
  logic [EW-1:0] eff_w;
  logic [EW-1:0] col_p1;
  logic    eol;
  logic    col_is0, col_is1, col_is2, col_is3;
  logic    is_dpcm;
  logic    raw_simple, raw_adv;
  pix_t    pred_simple, pred_adv, avg;
  pix_t    pix_nxt;

  // Handshakes
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;
  assign out_end_of_line = out_eol_r;

  // Clamp the line width and find the end of the line
  always_comb begin
    lw_ext = EW'(line_w_r);
    if (lw_ext == '0) begin
      eff_w = EW'(1);
    end else if (lw_ext > EW'(MAX_LINE_WIDTH)) begin
      eff_w = EW'(MAX_LINE_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
    col_p1  = EW'(col_r) + EW'(1);
    eol     = (col_p1 >= eff_w);
    col_nxt = eol ? '0 : col_p1[CW-1:0];
  end

  assign col_is0 = (col_r == CW'(0));
  assign col_is1 = (col_r == CW'(1));
  assign col_is2 = (col_r == CW'(2));
  assign col_is3 = (col_r == CW'(3));

  // Predictors: same-colour two back, and the advanced four-tap one
  assign raw_simple  = col_is0 || col_is1;
  assign raw_adv     = col_is0;
  assign pred_simple = raw_simple ? '0 : hist1_r;
  assign avg = PIXEL_BITS'(({1'b0, hist1_r} + {1'b0, hist3_r} + 13'd1) >> 1);

  always_comb begin
    if (col_is0) begin
      pred_adv = '0;
    end else if (col_is1) begin
      pred_adv = hist0_r;
    end else if (col_is2) begin
      pred_adv = hist1_r;
    end else if (ordered(hist0_r, hist1_r, hist1_r, hist2_r)) begin
      pred_adv = hist0_r;
    end else if (col_is3) begin
      pred_adv = hist1_r;
    end else if (ordered(hist0_r, hist2_r, hist1_r, hist3_r)) begin
      pred_adv = hist1_r;
    end else begin
      pred_adv = avg;
    end
  end

  // Decode per mode; unused codes fall back to bypass
  always_comb begin
    is_dpcm = 1'b1;
    case (mode_r)
      MODE_DPCM_10: pix_nxt = dec_10(raw_simple, s1_code_r[9:0], pred_simple);
      MODE_DPCM_8:  pix_nxt = dec_8(raw_simple, s1_code_r[7:0], pred_simple);
      MODE_DPCM_7:  pix_nxt = dec_7(raw_adv, s1_code_r[6:0], pred_adv);
      MODE_DPCM_6:  pix_nxt = dec_6(raw_adv, s1_code_r[5:0], pred_adv);
      default: begin
        is_dpcm = 1'b0;
        pix_nxt = s1_code_r;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RESET;
      line_w_r <= LINE_W_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CODEC_MODE) begin
        mode_r <= cfg_wdata[2:0];
      end else if (cfg_index == REG_LINE_WIDTH) begin
        line_w_r <= cfg_wdata[LINE_W_BITS-1:0];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_code_r <= in_code_word;
    end
  end

  // Output register, column counter and history advance together; history holds on bypass items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      col_r       <= '0;
      hist0_r     <= '0;
      hist1_r     <= '0;
      hist2_r     <= '0;
      hist3_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        col_r       <= col_nxt;
        if (is_dpcm) begin
          hist0_r <= pix_nxt;
          hist1_r <= hist0_r;
          hist2_r <= hist1_r;
          hist3_r <= hist2_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix_r <= pix_nxt;
      out_eol_r <= eol;
    end
  end

  // Checks
  a_eol_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && eol |=> col_r == '0)
    else $error("column counter did not wrap after end of line");

  a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !eol |=> col_r == ($past(col_r) + CW'(1)))
    else $error("column counter did not step by one");

  a_bypass_hist: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !is_dpcm |=> $stable(hist0_r) && $stable(hist3_r))
    else $error("history changed on a bypass item");

  a_eol_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eol_r |-> col_r == '0)
    else $error("pending end-of-line item but column counter not at zero");

endmodule

`default_nettype wire
